[rtl/fsa_pkg.sv]
// shared types, constants and helpers for the free list slot allocator
`default_nettype none

package fsa_pkg;

    // pool geometry (ALIGN_BYTES must be a power of two)
    localparam int SLOTS          = 256;
    localparam int ALIGN_BYTES    = 16;
    localparam int MIN_SLOT_BYTES = 8;

    // field widths
    localparam int IDXW     = $clog2(SLOTS);
    localparam int CAPW     = $clog2(SLOTS + 1);
    localparam int SCW      = 9;
    localparam int OBJW     = 13;
    localparam int STRW     = OBJW + 1;
    localparam int OFFW     = 20;
    localparam int FREEW    = 9;
    localparam int LIMW     = CAPW + STRW;
    localparam int CFGW     = 13;
    localparam int CFG_IDXW = 2;
    localparam int BITW     = (IDXW > 1) ? $clog2(IDXW) : 1;

    localparam logic [FREEW-1:0] FREE_MAX = FREEW'((1 << FREEW) - 1);

    // configuration reset values
    localparam logic [SCW-1:0]  RST_SLOT_COUNT   = SCW'(256);
    localparam logic [OBJW-1:0] RST_OBJECT_BYTES = OBJW'(16);

    // configuration register indexes
    localparam logic [CFG_IDXW-1:0] CFG_SLOT_COUNT   = CFG_IDXW'(0);
    localparam logic [CFG_IDXW-1:0] CFG_OBJECT_BYTES = CFG_IDXW'(1);

    // request operations
    localparam logic OP_TAKE   = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    typedef logic [IDXW-1:0] t_slot;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BOUNDS   = 2'd2,
        ST_MISALIGN = 2'd3
    } t_status;

    // one free list entry
    typedef struct packed {
        logic  end_of_list;
        t_slot link;
    } t_link;

    typedef struct packed {
        logic            op;
        logic [OFFW-1:0] return_offset;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [OFFW-1:0]  slot_offset;
        logic [FREEW-1:0] free_slots;
    } t_res;

    // divider status towards the control
    typedef struct packed {
        logic  done;
        logic  exact;
        t_slot quotient;
    } t_div_res;

    // stride: object size raised to the minimum, rounded up to the alignment
    function automatic logic [STRW-1:0] calc_stride(input logic [OBJW-1:0] obj);
        logic [STRW-1:0] size;
        size = STRW'(obj);
        if (size < STRW'(MIN_SLOT_BYTES)) begin
            size = STRW'(MIN_SLOT_BYTES);
        end
        return (size + STRW'(ALIGN_BYTES - 1)) & ~STRW'(ALIGN_BYTES - 1);
    endfunction

    // capacity: slot count clamped to one .. SLOTS
    function automatic logic [CAPW-1:0] capacity_of(input logic [SCW-1:0] cnt);
        logic [SCW+CAPW-1:0] c;
        c = (SCW + CAPW)'(cnt);
        if (c < (SCW + CAPW)'(1)) begin
            c = (SCW + CAPW)'(1);
        end
        if (c > (SCW + CAPW)'(SLOTS)) begin
            c = (SCW + CAPW)'(SLOTS);
        end
        return CAPW'(c);
    endfunction

endpackage

`default_nettype wire

[rtl/fsa_divider.sv]
// restoring divider, one quotient bit a cycle, offset by stride
`default_nettype none

module fsa_divider import fsa_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [OFFW-1:0] i_dividend,
    input  wire logic [STRW-1:0] i_divisor,
    output t_div_res             o_res
);

    logic            r_busy;
    logic [BITW-1:0] r_bit;
    logic [LIMW-1:0] r_rem;
    logic [STRW-1:0] r_div;
    t_slot           r_quo;
    logic            r_done;

    logic [LIMW-1:0] trial;
    logic            fits;

    // shifted divisor for the current quotient bit
    always_comb begin
        trial = LIMW'(r_div) << r_bit;
        fits  = (trial <= r_rem);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == BITW'(0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= LIMW'(i_dividend);
            r_div <= i_divisor;
            r_quo <= '0;
            r_bit <= BITW'(IDXW - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem        <= r_rem - trial;
                r_quo[r_bit] <= 1'b1;
            end
            if (r_bit != BITW'(0)) begin
                r_bit <= r_bit - BITW'(1);
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.exact    = (r_rem == '0);
    assign o_res.quotient = r_quo;

endmodule

`default_nettype wire

[rtl/free_list_slot_allocator.sv]
// free list slot allocator: lifo free list of fixed slots held in one memory
// a take gives its result from S_TAKE after the head entry is read; a good
// return gives it once the divider is done (one divider step per quotient bit);
// an empty take or an out of bounds return is answered from S_IDLE; one request at a time
// reset and every write to the slot count or object bytes register start a linking
// sweep over all SLOTS entries with busy high; results are strobed once, no stall
`default_nettype none

module free_list_slot_allocator import fsa_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire t_req                i_req,
    output logic                     o_busy,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [CFGW-1:0]     i_cfg_data,
    output logic                     o_res_valid,
    output t_res                     o_res
);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_TAKE,
        S_DIV
    } t_state;

    t_state           r_state;
    t_slot            r_init_idx;
    logic [SCW-1:0]   r_slot_count;
    logic [OBJW-1:0]  r_object_bytes;
    logic [STRW-1:0]  r_stride;
    logic [LIMW-1:0]  r_limit;
    t_slot            r_head;
    logic             r_head_end;
    logic [FREEW-1:0] r_free;
    logic [OFFW-1:0]  r_take_off;
    logic             r_res_valid;
    t_res             r_res;

    t_link            r_mem [SLOTS];
    t_link            r_rd;

    logic [CAPW-1:0]  cap;
    logic [FREEW-1:0] init_free;
    logic [FREEW-1:0] n_free_dec;
    logic [FREEW-1:0] n_free_inc;
    logic             mem_we;
    t_slot            mem_addr;
    t_link            mem_wdata;
    logic             div_start;
    t_div_res         div_res;
    logic             cfg_hit;

    // capacity and free count helpers
    always_comb begin
        cap = capacity_of(r_slot_count);
        if ((CAPW + FREEW)'(cap) > (CAPW + FREEW)'(FREE_MAX)) begin
            init_free = FREE_MAX;
        end else begin
            init_free = FREEW'(cap);
        end
        n_free_dec = (r_free != '0) ? r_free - FREEW'(1) : r_free;
        n_free_inc = (r_free != FREE_MAX) ? r_free + FREEW'(1) : r_free;
        cfg_hit    = i_cfg_we && (i_cfg_index == CFG_SLOT_COUNT ||
                                  i_cfg_index == CFG_OBJECT_BYTES);
    end

    // memory write: linking sweep or push of a returned slot
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_init_idx;
        mem_wdata = '{end_of_list: (CAPW'(r_init_idx) == cap - CAPW'(1)),
                      link: r_init_idx + IDXW'(1)};
        if (r_state == S_INIT) begin
            mem_we = 1'b1;
        end else if (r_state == S_DIV && div_res.done && div_res.exact) begin
            mem_we    = 1'b1;
            mem_addr  = div_res.quotient;
            mem_wdata = '{end_of_list: r_head_end, link: r_head};
        end
    end

    // free list memory, read at the head every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[r_head];
    end

    // return offset to slot index
    assign div_start = (r_state == S_IDLE) && i_start && (i_req.op == OP_RETURN) &&
                       (LIMW'(i_req.return_offset) < r_limit);

    fsa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.return_offset),
        .i_divisor  (r_stride),
        .o_res      (div_res)
    );

    // control state, list head, free count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_init_idx     <= '0;
            r_slot_count   <= RST_SLOT_COUNT;
            r_object_bytes <= RST_OBJECT_BYTES;
            r_head         <= '0;
            r_head_end     <= 1'b0;
            r_free         <= '0;
            r_res_valid    <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_stride   <= calc_stride(r_object_bytes);
                    r_limit    <= LIMW'(cap * r_stride);
                    r_head     <= '0;
                    r_head_end <= 1'b0;
                    r_free     <= init_free;
                    r_init_idx <= r_init_idx + IDXW'(1);
                    if (r_init_idx == IDXW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        if (i_req.op == OP_TAKE) begin
                            if (r_head_end) begin
                                r_res_valid       <= 1'b1;
                                r_res.status      <= ST_EMPTY;
                                r_res.slot_offset <= '0;
                                r_res.free_slots  <= r_free;
                            end else begin
                                r_take_off <= OFFW'(r_head * r_stride);
                                r_state    <= S_TAKE;
                            end
                        end else if (LIMW'(i_req.return_offset) >= r_limit) begin
                            r_res_valid       <= 1'b1;
                            r_res.status      <= ST_BOUNDS;
                            r_res.slot_offset <= '0;
                            r_res.free_slots  <= r_free;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_TAKE: begin
                    r_head            <= r_rd.link;
                    r_head_end        <= r_rd.end_of_list;
                    r_free            <= n_free_dec;
                    r_res_valid       <= 1'b1;
                    r_res.status      <= ST_OK;
                    r_res.slot_offset <= r_take_off;
                    r_res.free_slots  <= n_free_dec;
                    r_state           <= S_IDLE;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_res_valid       <= 1'b1;
                        r_res.slot_offset <= '0;
                        if (div_res.exact) begin
                            r_head           <= div_res.quotient;
                            r_head_end       <= 1'b0;
                            r_free           <= n_free_inc;
                            r_res.status     <= ST_OK;
                            r_res.free_slots <= n_free_inc;
                        end else begin
                            r_res.status     <= ST_MISALIGN;
                            r_res.free_slots <= r_free;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
            // a write to the slot count or object bytes register restarts the linking sweep
            if (i_cfg_we && i_cfg_index == CFG_SLOT_COUNT) begin
                r_slot_count <= i_cfg_data[SCW-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_OBJECT_BYTES) begin
                r_object_bytes <= i_cfg_data[OBJW-1:0];
            end
            if (cfg_hit) begin
                r_state    <= S_INIT;
                r_init_idx <= '0;
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire
